@@ hw/rtl/tmms_pkg.sv @@
// Shared constants and types for the thermistor min/max summary frame block.
package tmms_pkg;

	localparam int CELL_COUNT      = 72;
	localparam int MODULE_COUNT    = 6;
	localparam int HALF_OFFSET     = CELL_COUNT / MODULE_COUNT / 2;
	localparam int TEMPS_PER_FRAME = 6;

	localparam int CELL_IDX_W = $clog2(CELL_COUNT);
	localparam int ADDR_SUM_W = CELL_IDX_W + 1;
	localparam int TEMP_SEL_W = $clog2(TEMPS_PER_FRAME);

	localparam int ID_W     = 29;
	localparam int TEMP_W   = 8;
	localparam int BYTE_W   = 8;
	localparam int APB_DW   = 32;
	localparam int APB_AW   = 4;

	localparam logic [BYTE_W-1:0] ENABLED_COUNT = BYTE_W'(CELL_COUNT - 1);
	localparam logic [BYTE_W-1:0] CHECK_BIAS    = BYTE_W'(57 + 8);
	localparam logic [ID_W-1:0]   FIRST_ID_RST  = ID_W'(0);
	localparam logic [ID_W-1:0]   SECOND_ID_RST = ID_W'(1);

	typedef enum logic [1:0] {
		REG_MODULE_NUMBER = 2'd0,
		REG_FIRST_ID      = 2'd1,
		REG_SECOND_ID     = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [BYTE_W-1:0] module_number;
		logic [ID_W-1:0]   first_half_frame_id;
		logic [ID_W-1:0]   second_half_frame_id;
	} cfg_t;

	typedef struct packed {
		logic                  load;
		logic                  wr_en;
		logic                  rd_en;
		logic                  first;
		logic                  finish;
		logic [CELL_IDX_W-1:0] idx;
	} cmd_t;

	typedef struct packed {
		logic mode;
		logic hit_first;
		logic hit_second;
		logic out_busy;
	} status_t;

endpackage

@@ hw/rtl/tmms_if.sv @@
// Valid/ready channel interfaces for frame/request items and summary results.
interface tmms_item_if;
	logic                             valid;
	logic                             ready;
	logic                             mode;
	logic [tmms_pkg::ID_W-1:0]        frame_id;
	logic signed [tmms_pkg::TEMP_W-1:0] temp_a;
	logic signed [tmms_pkg::TEMP_W-1:0] temp_b;
	logic signed [tmms_pkg::TEMP_W-1:0] temp_c;
	logic signed [tmms_pkg::TEMP_W-1:0] temp_d;
	logic signed [tmms_pkg::TEMP_W-1:0] temp_e;
	logic signed [tmms_pkg::TEMP_W-1:0] temp_f;

	modport source (output valid, mode, frame_id, temp_a, temp_b, temp_c, temp_d, temp_e,
		temp_f, input ready);
	modport sink (input valid, mode, frame_id, temp_a, temp_b, temp_c, temp_d, temp_e,
		temp_f, output ready);
endinterface

interface tmms_result_if;
	logic                               valid;
	logic                               ready;
	logic [tmms_pkg::BYTE_W-1:0]        module_byte;
	logic signed [tmms_pkg::TEMP_W-1:0] lowest_temp;
	logic signed [tmms_pkg::TEMP_W-1:0] highest_temp;
	logic signed [tmms_pkg::TEMP_W-1:0] average_temp;
	logic [tmms_pkg::BYTE_W-1:0]        enabled_count;
	logic [tmms_pkg::BYTE_W-1:0]        highest_index;
	logic [tmms_pkg::BYTE_W-1:0]        lowest_index;
	logic [tmms_pkg::BYTE_W-1:0]        frame_checksum;

	modport source (output valid, module_byte, lowest_temp, highest_temp, average_temp,
		enabled_count, highest_index, lowest_index, frame_checksum, input ready);
	modport sink (input valid, module_byte, lowest_temp, highest_temp, average_temp,
		enabled_count, highest_index, lowest_index, frame_checksum, output ready);
endinterface

@@ hw/rtl/tmms_regs.sv @@
// APB configuration registers: module number and the two frame identifiers.
module tmms_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [tmms_pkg::APB_AW-1:0]   paddr,
	input  logic [tmms_pkg::APB_DW-1:0]   pwdata,
	output logic [tmms_pkg::APB_DW-1:0]   prdata,
	output logic                          pready,
	output tmms_pkg::cfg_t                cfg
);

	tmms_pkg::cfg_t     cfg_q;
	tmms_pkg::reg_idx_t reg_idx;
	logic               wr_en;

	assign pready  = 1'b1;
	assign reg_idx = tmms_pkg::reg_idx_t'(paddr[3:2]);
	assign wr_en   = psel & penable & pwrite;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.module_number        <= '0;
			cfg_q.first_half_frame_id  <= tmms_pkg::FIRST_ID_RST;
			cfg_q.second_half_frame_id <= tmms_pkg::SECOND_ID_RST;
		end else if (wr_en) begin
			unique case (reg_idx)
				tmms_pkg::REG_MODULE_NUMBER:
					cfg_q.module_number <= pwdata[tmms_pkg::BYTE_W-1:0];
				tmms_pkg::REG_FIRST_ID:
					cfg_q.first_half_frame_id <= pwdata[tmms_pkg::ID_W-1:0];
				tmms_pkg::REG_SECOND_ID:
					cfg_q.second_half_frame_id <= pwdata[tmms_pkg::ID_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			tmms_pkg::REG_MODULE_NUMBER:
				prdata = tmms_pkg::APB_DW'(cfg_q.module_number);
			tmms_pkg::REG_FIRST_ID:
				prdata = tmms_pkg::APB_DW'(cfg_q.first_half_frame_id);
			tmms_pkg::REG_SECOND_ID:
				prdata = tmms_pkg::APB_DW'(cfg_q.second_half_frame_id);
			default:
				prdata = '0;
		endcase
	end

endmodule

@@ hw/rtl/tmms_ctrl.sv @@
// Controller: sequences frame writes and the summary scan over the cell store.
module tmms_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_ready,
	input  tmms_pkg::status_t  status,
	output tmms_pkg::cmd_t     cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_WRITE,
		ST_SCAN,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	state_t                          state_q;
	logic [tmms_pkg::CELL_IDX_W-1:0] cnt_q;
	logic                            last_wr;
	logic                            last_rd;

	assign last_wr = cnt_q == tmms_pkg::CELL_IDX_W'(tmms_pkg::TEMPS_PER_FRAME - 1);
	assign last_rd = cnt_q == tmms_pkg::CELL_IDX_W'(tmms_pkg::CELL_COUNT - 1);

	assign item_ready = state_q == ST_IDLE;

	always_comb begin
		cmd        = '0;
		cmd.idx    = cnt_q;
		cmd.load   = item_ready & item_valid;
		cmd.wr_en  = state_q == ST_WRITE;
		cmd.rd_en  = state_q == ST_SCAN;
		cmd.first  = (state_q == ST_SCAN) && (cnt_q == '0);
		cmd.finish = (state_q == ST_FINISH) && !status.out_busy;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (item_valid) begin
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					if (status.mode) begin
						state_q <= ST_SCAN;
					end else if (status.hit_first || status.hit_second) begin
						state_q <= ST_WRITE;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_WRITE: begin
					if (last_wr) begin
						state_q <= ST_IDLE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_SCAN: begin
					if (last_rd) begin
						state_q <= ST_DRAIN;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (!status.out_busy) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

@@ hw/rtl/tmms_dpath.sv @@
// Datapath: item latch, cell store, min/max scan and summary output register.
module tmms_dpath (
	input  logic                       clk,
	input  logic                       arst_n,
	input  tmms_pkg::cfg_t             cfg,
	input  tmms_pkg::cmd_t             cmd,
	output tmms_pkg::status_t          status,
	tmms_item_if.sink                  item,
	tmms_result_if.source              result
);

	localparam int CW = tmms_pkg::CELL_IDX_W;
	localparam int TW = tmms_pkg::TEMP_W;
	localparam int BW = tmms_pkg::BYTE_W;

	// item latch
	logic                       mode_q;
	logic [tmms_pkg::ID_W-1:0]  id_q;
	logic signed [TW-1:0]       temps_q [tmms_pkg::TEMPS_PER_FRAME];

	// cell store, entries not yet written read as zero
	logic [TW-1:0]              cell_mem [tmms_pkg::CELL_COUNT];
	logic [tmms_pkg::CELL_COUNT-1:0] cell_vld_q;

	logic                       hit_first;
	logic                       hit_second;
	logic [tmms_pkg::ADDR_SUM_W-1:0] wr_sum;
	logic [CW-1:0]              wr_addr;
	logic                       wr_ok;
	logic signed [TW-1:0]       wr_data;

	// scan stage
	logic                       rd_s1;
	logic                       first_s1;
	logic [CW-1:0]              idx_s1;
	logic [TW-1:0]              rdata_s1;
	logic                       vbit_s1;
	logic signed [TW-1:0]       cur_t;

	logic signed [TW-1:0]       lo_q;
	logic signed [TW-1:0]       hi_q;
	logic [CW-1:0]              lo_idx_q;
	logic [CW-1:0]              hi_idx_q;

	logic [TW:0]                pair_sum;
	logic [TW:0]                pair_adj;
	logic signed [TW-1:0]       avg;
	logic [BW-1:0]              lo_idx_b;
	logic [BW-1:0]              hi_idx_b;
	logic [BW-1:0]              checksum;

	logic                       out_valid_q;
	logic [BW-1:0]              module_byte_q;
	logic signed [TW-1:0]       lowest_q;
	logic signed [TW-1:0]       highest_q;
	logic signed [TW-1:0]       average_q;
	logic [BW-1:0]              highest_index_q;
	logic [BW-1:0]              lowest_index_q;
	logic [BW-1:0]              checksum_q;

	assign item.ready = cmd.load | ~item.valid ? cmd.load : 1'b0;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q     <= item.mode;
			id_q       <= item.frame_id;
			temps_q[0] <= item.temp_a;
			temps_q[1] <= item.temp_b;
			temps_q[2] <= item.temp_c;
			temps_q[3] <= item.temp_d;
			temps_q[4] <= item.temp_e;
			temps_q[5] <= item.temp_f;
		end
	end

	assign hit_first  = id_q == cfg.first_half_frame_id;
	assign hit_second = id_q == cfg.second_half_frame_id;

	assign status.mode       = mode_q;
	assign status.hit_first  = hit_first;
	assign status.hit_second = hit_second;
	assign status.out_busy   = out_valid_q;

	// frame write: one temperature per cycle, first identifier wins
	assign wr_sum  = (hit_first ? '0 : tmms_pkg::ADDR_SUM_W'(tmms_pkg::HALF_OFFSET))
		+ tmms_pkg::ADDR_SUM_W'(cmd.idx);
	assign wr_addr = wr_sum[CW-1:0];
	assign wr_ok   = cmd.wr_en && (wr_sum < tmms_pkg::ADDR_SUM_W'(tmms_pkg::CELL_COUNT));
	assign wr_data = temps_q[cmd.idx[tmms_pkg::TEMP_SEL_W-1:0]];

	always_ff @(posedge clk) begin
		if (wr_ok) begin
			cell_mem[wr_addr] <= wr_data;
		end
		if (cmd.rd_en) begin
			rdata_s1 <= cell_mem[cmd.idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_vld_q <= '0;
			rd_s1      <= 1'b0;
			first_s1   <= 1'b0;
			idx_s1     <= '0;
			vbit_s1    <= 1'b0;
		end else begin
			if (wr_ok) begin
				cell_vld_q[wr_addr] <= 1'b1;
			end
			rd_s1    <= cmd.rd_en;
			first_s1 <= cmd.first;
			idx_s1   <= cmd.idx;
			vbit_s1  <= cell_vld_q[cmd.idx];
		end
	end

	assign cur_t = vbit_s1 ? $signed(rdata_s1) : '0;

	// running min/max, strict compares keep the first index
	always_ff @(posedge clk) begin
		if (rd_s1) begin
			if (first_s1) begin
				lo_q     <= cur_t;
				hi_q     <= cur_t;
				lo_idx_q <= idx_s1;
				hi_idx_q <= idx_s1;
			end else begin
				if (cur_t < lo_q) begin
					lo_q     <= cur_t;
					lo_idx_q <= idx_s1;
				end
				if (cur_t > hi_q) begin
					hi_q     <= cur_t;
					hi_idx_q <= idx_s1;
				end
			end
		end
	end

	// (lo + hi) / 2 rounded toward zero
	assign pair_sum = {lo_q[TW-1], lo_q} + {hi_q[TW-1], hi_q};
	assign pair_adj = pair_sum + {{TW{1'b0}}, pair_sum[TW]};
	assign avg      = $signed(pair_adj[TW:1]);
	assign lo_idx_b = BW'(lo_idx_q);
	assign hi_idx_b = BW'(hi_idx_q);
	assign checksum = cfg.module_number + lo_q + hi_q + avg + tmms_pkg::ENABLED_COUNT
		+ hi_idx_b + lo_idx_b + tmms_pkg::CHECK_BIAS;

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			module_byte_q   <= cfg.module_number;
			lowest_q        <= lo_q;
			highest_q       <= hi_q;
			average_q       <= avg;
			highest_index_q <= hi_idx_b;
			lowest_index_q  <= lo_idx_b;
			checksum_q      <= checksum;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign result.valid          = out_valid_q;
	assign result.module_byte    = module_byte_q;
	assign result.lowest_temp    = lowest_q;
	assign result.highest_temp   = highest_q;
	assign result.average_temp   = average_q;
	assign result.enabled_count  = tmms_pkg::ENABLED_COUNT;
	assign result.highest_index  = highest_index_q;
	assign result.lowest_index   = lowest_index_q;
	assign result.frame_checksum = checksum_q;

	a_finish_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> out_valid_q)
		else $error("summary not presented after finish");

	a_finish_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> !out_valid_q)
		else $error("summary overwritten before transaction completed");

	a_no_write_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.wr_en && cmd.rd_en))
		else $error("cell store written during scan");

	a_low_not_above_high: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (lowest_q <= highest_q) && (lowest_q <= average_q)
			&& (average_q <= highest_q))
		else $error("summary min/avg/max out of order");

endmodule

@@ hw/rtl/thermistor_min_max_summary_frame.sv @@
// Top level of the thermistor min/max summary frame block.
// Keeps 72 signed 8-bit cell temperatures (zero after reset). A frame item (mode 0) whose
// identifier equals first_half_frame_id writes its six temperatures at cells 0..5, else one
// equal to second_half_frame_id writes them from cell CELL_COUNT/MODULE_COUNT/2; others are
// dropped. A frame passes through the load state and, when it matches, makes one store write
// per cycle. A send request (mode 1) reads the store one cell per cycle through its single
// read port; the summary lands in the output register in the finish state, after the scan and
// drain states, and the next item can be taken in the following cycle, even while the summary
// still waits on the result channel; a following request holds its summary until the
// previous one has been taken.
// Registers at byte addresses 0 (module number), 4 (first id), 8 (second id).
module thermistor_min_max_summary_frame (
	input  logic                           clk,
	input  logic                           arst_n,
	tmms_item_if.sink                      item,
	tmms_result_if.source                  result,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [tmms_pkg::APB_AW-1:0]    paddr,
	input  logic [tmms_pkg::APB_DW-1:0]    pwdata,
	output logic [tmms_pkg::APB_DW-1:0]    prdata,
	output logic                           pready
);

	tmms_pkg::cfg_t    cfg;
	tmms_pkg::cmd_t    cmd;
	tmms_pkg::status_t status;
	logic              item_ready;

	tmms_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	tmms_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item.valid),
		.item_ready (item_ready),
		.status     (status),
		.cmd        (cmd)
	);

	tmms_dpath u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.cmd    (cmd),
		.status (status),
		.item   (item),
		.result (result)
	);

	a_ready_matches_ctrl: assert property (@(posedge clk) disable iff (!arst_n)
		item.ready == (item_ready & item.valid) || !item.valid)
		else $error("item ready disagrees with controller");

endmodule
